### rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile every check out of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PBMP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pbmp parser check failed");
`define PBMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbmp parser implication failed");
`else
`define PBMP_ASSERT(label, clk, rst_n, prop)
`define PBMP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pbmp_pkg.sv
// Types, character constants, result and error codes for the P4 stream parser.
// Used by pbmp_step_engine and pbm_p4_stream_parser_core; depends on nothing.
package pbmp_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  pixel_byte;
        logic        last_byte;
        logic [3:0]  error_code;
    } result_t;

    typedef struct packed {
        logic    has_result;
        result_t data;
    } step_out_t;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_EOS  = 1'b1;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_SHORT_MAGIC   = 4'd0;
    localparam logic [3:0] ERR_BAD_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_SPACE_MAGIC   = 4'd2;
    localparam logic [3:0] ERR_NO_WIDTH      = 4'd3;
    localparam logic [3:0] ERR_SPACE_WIDTH   = 4'd4;
    localparam logic [3:0] ERR_NO_HEIGHT     = 4'd5;
    localparam logic [3:0] ERR_ZERO_HEIGHT   = 4'd6;
    localparam logic [3:0] ERR_ZERO_WIDTH    = 4'd7;
    localparam logic [3:0] ERR_SPACE_HEIGHT  = 4'd8;
    localparam logic [3:0] ERR_SHORT_RASTER  = 4'd9;
    localparam logic [3:0] ERR_TOO_LARGE     = 4'd10;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Tab, LF, VT, FF, CR and space; NUL is not whitespace.
    function automatic logic is_space(input logic [7:0] b);
        return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

endpackage

### rtl/pbmp_step_engine.sv
// Header state machine and raster counter of the P4 parser: one byte per step.
// Depends on pbmp_pkg for the item, result and error code definitions.
module pbmp_step_engine #(
    parameter int MAX_DIM = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  pbmp_pkg::item_t     item,
    output pbmp_pkg::step_out_t step_out
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = DIM_W + 4;
    localparam int ROW_W = DIM_W - 2;
    localparam int RAS_W = ROW_W + DIM_W;

    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_SPACE_A = 4'd2;
    localparam logic [3:0] PH_WIDTH   = 4'd3;
    localparam logic [3:0] PH_SPACE_B = 4'd4;
    localparam logic [3:0] PH_HEIGHT  = 4'd5;
    localparam logic [3:0] PH_FINAL   = 4'd6;
    localparam logic [3:0] PH_RASTER  = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;
    localparam logic [3:0] PH_FAILED  = 4'd9;

    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       magic_reg, magic_next;
    logic             seen_reg, seen_next;
    logic             cmt_reg, cmt_next;
    logic [DIM_W-1:0] acc_reg, acc_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [RAS_W-1:0] ras_reg, ras_next;

    logic [7:0]       b;
    logic             number_phase;
    logic [DIM_W-1:0] acc_src;
    logic             seen_src;
    logic [ACC_W-1:0] acc_scaled;
    logic             too_large;
    logic [DIM_W-1:0] h_src;
    logic [DIM_W:0]   width_pad;
    logic [ROW_W-1:0] row_cnt;
    logic [RAS_W-1:0] ras_total;

    logic             go_number;
    logic             num_is_width;
    logic             go_ws;
    logic             fail_en;
    logic [3:0]       fail_code;
    logic             hdr_en;

    assign b            = item.byte_value;
    assign number_phase = phase_reg inside {PH_WIDTH, PH_HEIGHT};

    // A number entered from a whitespace phase starts from an empty accumulator.
    assign acc_src    = number_phase ? acc_reg : '0;
    assign seen_src   = number_phase ? seen_reg : 1'b0;
    assign acc_scaled = ACC_W'({acc_src, 3'b000}) + ACC_W'({acc_src, 1'b0})
                      + ACC_W'(b[3:0]);
    assign too_large  = acc_scaled > ACC_W'(MAX_DIM);

    // The height is still in the accumulator when the header follows the height digits.
    assign h_src     = (phase_reg == PH_HEIGHT) ? acc_reg : height_reg;
    assign width_pad = {1'b0, width_reg} + (DIM_W + 1)'(7);
    assign row_cnt   = width_pad[DIM_W:3];
    assign ras_total = RAS_W'(row_cnt) * RAS_W'(h_src);

    always_comb
    begin
        phase_next   = phase_reg;
        magic_next   = magic_reg;
        seen_next    = seen_reg;
        cmt_next     = cmt_reg;
        acc_next     = acc_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        ras_next     = ras_reg;
        step_out     = '0;
        go_number    = 1'b0;
        num_is_width = (phase_reg == PH_SPACE_A) || (phase_reg == PH_WIDTH);
        go_ws        = 1'b0;
        fail_en      = 1'b0;
        fail_code    = pbmp_pkg::ERR_SHORT_MAGIC;
        hdr_en       = 1'b0;

        if (item.op == pbmp_pkg::OP_EOS)
        begin
            phase_next  = PH_MAGIC0;
            magic_next  = '0;
            seen_next   = 1'b0;
            cmt_next    = 1'b0;
            acc_next    = '0;
            width_next  = '0;
            height_next = '0;
            ras_next    = '0;
            step_out.has_result      = 1'b1;
            step_out.data.kind       = pbmp_pkg::KIND_ERROR;
            case (phase_reg)
                PH_MAGIC0, PH_MAGIC1: step_out.data.error_code = pbmp_pkg::ERR_SHORT_MAGIC;
                PH_SPACE_A:           step_out.data.error_code = pbmp_pkg::ERR_SPACE_MAGIC;
                PH_WIDTH:             step_out.data.error_code = pbmp_pkg::ERR_NO_WIDTH;
                PH_SPACE_B:           step_out.data.error_code = pbmp_pkg::ERR_SPACE_WIDTH;
                PH_HEIGHT:            step_out.data.error_code = pbmp_pkg::ERR_NO_HEIGHT;
                PH_FINAL:             step_out.data.error_code = pbmp_pkg::ERR_SPACE_HEIGHT;
                PH_RASTER:            step_out.data.error_code = pbmp_pkg::ERR_SHORT_RASTER;
                default:
                begin
                    step_out.has_result = 1'b0;
                    step_out.data.kind  = pbmp_pkg::KIND_HEADER;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC0:
                begin
                    magic_next = b;
                    phase_next = PH_MAGIC1;
                end
                PH_MAGIC1:
                begin
                    if (magic_reg != pbmp_pkg::CH_P || b != pbmp_pkg::CH_FOUR)
                    begin
                        fail_en   = 1'b1;
                        fail_code = pbmp_pkg::ERR_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_SPACE_A;
                        seen_next  = 1'b0;
                        cmt_next   = 1'b0;
                    end
                end
                PH_SPACE_A, PH_SPACE_B, PH_FINAL:
                begin
                    if (cmt_reg)
                    begin
                        if (pbmp_pkg::is_eol(b))
                            cmt_next = 1'b0;
                    end
                    else if (b == pbmp_pkg::CH_HASH)
                        cmt_next = 1'b1;
                    else if (phase_reg == PH_FINAL)
                    begin
                        if (pbmp_pkg::is_space(b))
                            hdr_en = 1'b1;
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = pbmp_pkg::ERR_SPACE_HEIGHT;
                        end
                    end
                    else if (pbmp_pkg::is_space(b))
                        seen_next = 1'b1;
                    else if (!seen_reg)
                    begin
                        fail_en   = 1'b1;
                        fail_code = (phase_reg == PH_SPACE_A) ? pbmp_pkg::ERR_SPACE_MAGIC
                                                              : pbmp_pkg::ERR_SPACE_WIDTH;
                    end
                    else
                    begin
                        // This byte is the first character of the number.
                        phase_next = (phase_reg == PH_SPACE_A) ? PH_WIDTH : PH_HEIGHT;
                        seen_next  = 1'b0;
                        acc_next   = '0;
                        go_number  = 1'b1;
                    end
                end
                PH_WIDTH, PH_HEIGHT:
                    go_number = 1'b1;
                PH_RASTER:
                begin
                    step_out.has_result      = 1'b1;
                    step_out.data.kind       = pbmp_pkg::KIND_PIXEL;
                    step_out.data.pixel_byte = b;
                    step_out.data.last_byte  = ras_reg <= RAS_W'(1);
                    ras_next = ras_reg - RAS_W'(ras_reg != '0);
                    if (ras_reg <= RAS_W'(1))
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (go_number)
            begin
                if (pbmp_pkg::is_digit(b))
                begin
                    seen_next = 1'b1;
                    if (too_large)
                    begin
                        fail_en   = 1'b1;
                        fail_code = pbmp_pkg::ERR_TOO_LARGE;
                    end
                    else
                        acc_next = DIM_W'(acc_scaled);
                end
                else if (!seen_src)
                begin
                    fail_en   = 1'b1;
                    fail_code = num_is_width ? pbmp_pkg::ERR_NO_WIDTH
                                             : pbmp_pkg::ERR_NO_HEIGHT;
                end
                else if (num_is_width)
                begin
                    width_next = acc_reg;
                    phase_next = PH_SPACE_B;
                    seen_next  = 1'b0;
                    cmt_next   = 1'b0;
                    go_ws      = 1'b1;
                end
                else
                begin
                    height_next = acc_reg;
                    if (acc_reg == '0)
                    begin
                        fail_en   = 1'b1;
                        fail_code = pbmp_pkg::ERR_ZERO_HEIGHT;
                    end
                    else if (width_reg == '0)
                    begin
                        fail_en   = 1'b1;
                        fail_code = pbmp_pkg::ERR_ZERO_WIDTH;
                    end
                    else
                    begin
                        phase_next = PH_FINAL;
                        seen_next  = 1'b0;
                        cmt_next   = 1'b0;
                        go_ws      = 1'b1;
                    end
                end
            end

            // The byte that ended a number opens the following whitespace phase.
            if (go_ws)
            begin
                if (b == pbmp_pkg::CH_HASH)
                    cmt_next = 1'b1;
                else if (pbmp_pkg::is_space(b))
                begin
                    if (phase_next == PH_SPACE_B)
                        seen_next = 1'b1;
                    else
                        hdr_en = 1'b1;
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = (phase_next == PH_SPACE_B) ? pbmp_pkg::ERR_SPACE_WIDTH
                                                           : pbmp_pkg::ERR_SPACE_HEIGHT;
                end
            end

            if (hdr_en)
            begin
                ras_next   = ras_total;
                phase_next = PH_RASTER;
                step_out.has_result        = 1'b1;
                step_out.data.kind         = pbmp_pkg::KIND_HEADER;
                step_out.data.image_width  = 16'(width_reg);
                step_out.data.image_height = 16'(h_src);
            end

            if (fail_en)
            begin
                phase_next = PH_FAILED;
                step_out.has_result      = 1'b1;
                step_out.data.kind       = pbmp_pkg::KIND_ERROR;
                step_out.data.error_code = fail_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC0;
            magic_reg  <= '0;
            seen_reg   <= 1'b0;
            cmt_reg    <= 1'b0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            ras_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            magic_reg  <= magic_next;
            seen_reg   <= seen_next;
            cmt_reg    <= cmt_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            ras_reg    <= ras_next;
        end
    end

endmodule

### rtl/pbm_p4_stream_parser_core.sv
// Top level of the binary PBM (P4) stream parser: input register, step engine, result register.
// Depends on pbmp_pkg, pbmp_step_engine and assert_macros.svh.

// The parser takes one file byte or end-of-stream mark per clock unless the consumer stalls,
// and gives at most one result per item through the input register, then the result register.
// Each item is handled by the header state machine in a single step; the raster byte
// count is formed with one multiplier when the header completes. Results that wait on a
// stalled consumer do not block the next input, which is held in the input register.
// An end-of-stream mark always returns the parser to its reset state. MAX_DIM bounds the
// width and height and sets the internal counter widths.
`include "assert_macros.svh"

module pbm_p4_stream_parser_core #(
    parameter int MAX_DIM = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pbmp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output pbmp_pkg::result_t result
);

    logic                in_valid_reg, in_valid_next;
    pbmp_pkg::item_t     in_data_reg;
    logic                out_valid_reg, out_valid_next;
    pbmp_pkg::result_t   out_data_reg;
    logic                advance;
    logic                fire;
    pbmp_pkg::step_out_t step_out;

    // The held item moves on whenever the result register is free or being drained.
    assign advance    = !out_valid_reg || result_ready;
    assign fire       = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;

    assign in_valid_next  = item_ready ? item_valid : in_valid_reg;
    assign out_valid_next = advance ? (fire && step_out.has_result) : out_valid_reg;

    pbmp_step_engine #(
        .MAX_DIM (MAX_DIM)
    ) u_step_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (in_data_reg),
        .step_out (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_data_reg <= item;
        if (fire && step_out.has_result)
            out_data_reg <= step_out.data;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `PBMP_ASSERT_IMP(a_kind_known, clk, rst_n, result_valid, result.kind == pbmp_pkg::KIND_HEADER || result.kind == pbmp_pkg::KIND_PIXEL || result.kind == pbmp_pkg::KIND_ERROR)
    `PBMP_ASSERT_IMP(a_last_on_pixel, clk, rst_n, result_valid && result.last_byte, result.kind == pbmp_pkg::KIND_PIXEL)
    `PBMP_ASSERT_IMP(a_error_clean, clk, rst_n, result_valid && result.kind == pbmp_pkg::KIND_ERROR, result.error_code <= pbmp_pkg::ERR_TOO_LARGE && result.image_width == 16'd0 && result.image_height == 16'd0)
    `PBMP_ASSERT(a_held_item, clk, rst_n, in_valid_reg && !fire |=> in_valid_reg && $stable(in_data_reg))

endmodule

### tb/sv/tb_pbm_p4_stream_parser_core.sv
// Self-checking testbench for pbm_p4_stream_parser_core: directed P4 headers, then random files.
// Depends on pbmp_pkg for the transaction types, codes and characters, and on the core itself.
// A behavioral header parser in this module predicts every unpinned result, checked field by field.
module tb_pbm_p4_stream_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_LIMIT    = 65535;
    localparam int NUM_DIRECTED = 29;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTED  = 30;

    typedef enum logic [3:0] {
        PH_MAGIC0, PH_MAGIC1, PH_SPACE_A, PH_WIDTH, PH_SPACE_B,
        PH_HEIGHT, PH_FINAL, PH_RASTER, PH_DONE, PH_FAILED
    } parse_phase_t;

    // One line of the directed table; pinned rows carry their own expectation.
    typedef struct packed {
        pbmp_pkg::item_t   stim;
        logic              pinned;
        logic              pinned_has;
        pbmp_pkg::result_t pinned_res;
    } stim_row_t;

    localparam pbmp_pkg::result_t NO_RESULT = '0;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    pbmp_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    pbmp_pkg::result_t result;

    // Header parser state.
    parse_phase_t parse_phase;
    logic [7:0]   magic_first;
    bit           digit_or_blank_seen;
    bit           comment_open;
    int           num_value;
    logic [15:0]  width_seen;
    logic [15:0]  height_seen;
    longint       raster_left;

    pbmp_pkg::result_t expected_results[$];
    logic [7:0]        file_bytes[$];
    stim_row_t         directed_rows [NUM_DIRECTED];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int items_sent = 0;
    int input_stall_cycles = 0;
    int mismatch_count = 0;
    int headers_seen = 0;
    int pixels_seen = 0;
    int errors_seen = 0;

    pbm_p4_stream_parser_core #(
        .MAX_DIM(DIM_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pbmp_pkg::result_t error_result(input logic [3:0] code);
        pbmp_pkg::result_t r;
        r = '0;
        r.kind = pbmp_pkg::KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic pbmp_pkg::result_t header_result(input logic [15:0] w,
                                                        input logic [15:0] h);
        pbmp_pkg::result_t r;
        r = '0;
        r.kind = pbmp_pkg::KIND_HEADER;
        r.image_width = w;
        r.image_height = h;
        return r;
    endfunction

    function automatic pbmp_pkg::result_t pixel_result(input logic [7:0] b, input logic last);
        pbmp_pkg::result_t r;
        r = '0;
        r.kind = pbmp_pkg::KIND_PIXEL;
        r.pixel_byte = b;
        r.last_byte = last;
        return r;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        case (b)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_parser();
        parse_phase = PH_MAGIC0;
        magic_first = '0;
        digit_or_blank_seen = 1'b0;
        comment_open = 1'b0;
        num_value = 0;
        width_seen = '0;
        height_seen = '0;
        raster_left = 0;
    endfunction

    function automatic pbmp_pkg::result_t fail_with(input logic [3:0] code);
        parse_phase = PH_FAILED;
        return error_result(code);
    endfunction

    // Advances the parser by one transaction; returns 1 when a result is due.
    function automatic bit parse_item(input pbmp_pkg::item_t it,
                                      output pbmp_pkg::result_t res);
        logic [7:0] b;
        bit         rerun;
        bit         has;
        bit         last;
        b = it.byte_value;
        res = NO_RESULT;
        has = 1'b0;
        if (it.op == pbmp_pkg::OP_EOS)
        begin
            has = 1'b1;
            case (parse_phase)
                PH_MAGIC0, PH_MAGIC1: res = error_result(pbmp_pkg::ERR_SHORT_MAGIC);
                PH_SPACE_A:           res = error_result(pbmp_pkg::ERR_SPACE_MAGIC);
                PH_WIDTH:             res = error_result(pbmp_pkg::ERR_NO_WIDTH);
                PH_SPACE_B:           res = error_result(pbmp_pkg::ERR_SPACE_WIDTH);
                PH_HEIGHT:            res = error_result(pbmp_pkg::ERR_NO_HEIGHT);
                PH_FINAL:             res = error_result(pbmp_pkg::ERR_SPACE_HEIGHT);
                PH_RASTER:            res = error_result(pbmp_pkg::ERR_SHORT_RASTER);
                default:              has = 1'b0;
            endcase
            clear_parser();
            return has;
        end
        rerun = 1'b1;
        while (rerun)
        begin
            rerun = 1'b0;
            case (parse_phase)
                PH_MAGIC0:
                begin
                    magic_first = b;
                    parse_phase = PH_MAGIC1;
                end
                PH_MAGIC1:
                begin
                    if (magic_first != pbmp_pkg::CH_P || b != pbmp_pkg::CH_FOUR)
                    begin
                        res = fail_with(pbmp_pkg::ERR_BAD_MAGIC);
                        has = 1'b1;
                    end
                    else
                    begin
                        parse_phase = PH_SPACE_A;
                        digit_or_blank_seen = 1'b0;
                        comment_open = 1'b0;
                    end
                end
                PH_SPACE_A, PH_SPACE_B, PH_FINAL:
                begin
                    if (comment_open)
                    begin
                        if (b == pbmp_pkg::CH_CR || b == pbmp_pkg::CH_LF)
                            comment_open = 1'b0;
                    end
                    else if (b == pbmp_pkg::CH_HASH)
                        comment_open = 1'b1;
                    else if (parse_phase == PH_FINAL)
                    begin
                        has = 1'b1;
                        if (!is_blank(b))
                            res = fail_with(pbmp_pkg::ERR_SPACE_HEIGHT);
                        else
                        begin
                            raster_left = longint'((int'(width_seen) + 7) / 8)
                                          * longint'(height_seen);
                            parse_phase = PH_RASTER;
                            res = header_result(width_seen, height_seen);
                        end
                    end
                    else if (is_blank(b))
                        digit_or_blank_seen = 1'b1;
                    else if (!digit_or_blank_seen)
                    begin
                        res = fail_with(parse_phase == PH_SPACE_A
                                        ? pbmp_pkg::ERR_SPACE_MAGIC
                                        : pbmp_pkg::ERR_SPACE_WIDTH);
                        has = 1'b1;
                    end
                    else
                    begin
                        // The byte that ends the blank run starts the number.
                        parse_phase = (parse_phase == PH_SPACE_A) ? PH_WIDTH : PH_HEIGHT;
                        digit_or_blank_seen = 1'b0;
                        num_value = 0;
                        rerun = 1'b1;
                    end
                end
                PH_WIDTH, PH_HEIGHT:
                begin
                    if (b >= pbmp_pkg::CH_ZERO && b <= pbmp_pkg::CH_NINE)
                    begin
                        num_value = num_value * 10 + int'(b - pbmp_pkg::CH_ZERO);
                        digit_or_blank_seen = 1'b1;
                        if (num_value > DIM_LIMIT)
                        begin
                            res = fail_with(pbmp_pkg::ERR_TOO_LARGE);
                            has = 1'b1;
                        end
                    end
                    else if (!digit_or_blank_seen)
                    begin
                        res = fail_with(parse_phase == PH_WIDTH ? pbmp_pkg::ERR_NO_WIDTH
                                                                : pbmp_pkg::ERR_NO_HEIGHT);
                        has = 1'b1;
                    end
                    else if (parse_phase == PH_WIDTH)
                    begin
                        width_seen = 16'(num_value);
                        parse_phase = PH_SPACE_B;
                        digit_or_blank_seen = 1'b0;
                        comment_open = 1'b0;
                        rerun = 1'b1;
                    end
                    else
                    begin
                        height_seen = 16'(num_value);
                        if (height_seen == 0)
                        begin
                            res = fail_with(pbmp_pkg::ERR_ZERO_HEIGHT);
                            has = 1'b1;
                        end
                        else if (width_seen == 0)
                        begin
                            res = fail_with(pbmp_pkg::ERR_ZERO_WIDTH);
                            has = 1'b1;
                        end
                        else
                        begin
                            parse_phase = PH_FINAL;
                            digit_or_blank_seen = 1'b0;
                            comment_open = 1'b0;
                            rerun = 1'b1;
                        end
                    end
                end
                PH_RASTER:
                begin
                    last = (raster_left <= 1);
                    if (raster_left > 0)
                        raster_left--;
                    if (last)
                        parse_phase = PH_DONE;
                    res = pixel_result(b, last);
                    has = 1'b1;
                end
                default: ;
            endcase
        end
        return has;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offers one transaction and books its expectation at the edge that accepts it.
    task automatic send_item(input stim_row_t row);
        pbmp_pkg::result_t res;
        bit                has;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = row.stim;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        has = parse_item(row.stim, res);
        if (row.pinned)
        begin
            has = row.pinned_has;
            res = row.pinned_res;
        end
        if (has)
            expected_results.push_back(res);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return 8'h09;
            1: return pbmp_pkg::CH_LF;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return pbmp_pkg::CH_CR;
            default: return 8'h20;
        endcase
    endfunction

    task automatic push_comment();
        file_bytes.push_back(pbmp_pkg::CH_HASH);
        repeat ($urandom_range(0, 4))
            file_bytes.push_back(8'($urandom_range(8'h0E, 8'hFF)));
        file_bytes.push_back($urandom_range(0, 1) ? pbmp_pkg::CH_CR : pbmp_pkg::CH_LF);
    endtask

    task automatic push_blanks(input bit exactly_one);
        if ($urandom_range(0, 3) == 0)
            push_comment();
        if (exactly_one)
            file_bytes.push_back(pick_blank());
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                file_bytes.push_back(pick_blank());
                if ($urandom_range(0, 7) == 0)
                    push_comment();
            end
        end
    endtask

    task automatic push_number(input int value);
        string digits;
        if ($urandom_range(0, 3) == 0)
            file_bytes.push_back(pbmp_pkg::CH_ZERO);
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++)
            file_bytes.push_back(digits[i]);
    endtask

    function automatic int pick_dimension(input bit is_height);
        int r;
        r = $urandom_range(0, 99);
        if (is_height)
        begin
            if (r < 75) return $urandom_range(1, 3);
            if (r < 81) return $urandom_range(4, 12);
            if (r < 85) return $urandom_range(DIM_LIMIT - 5, DIM_LIMIT);
            if (r < 91) return 0;
            if (r < 95) return $urandom_range(DIM_LIMIT + 1, 999999);
            return $urandom_range(1, DIM_LIMIT);
        end
        if (r < 65) return $urandom_range(1, 24);
        if (r < 75) return $urandom_range(25, 120);
        if (r < 80) return $urandom_range(DIM_LIMIT - 7, DIM_LIMIT);
        if (r < 86) return 0;
        if (r < 91) return $urandom_range(DIM_LIMIT + 1, 999999);
        return $urandom_range(1, DIM_LIMIT);
    endfunction

    // Mostly well-formed files with random content; some get a bad magic, a stray
    // byte or a cut header. Large images always end early to keep the run short.
    task automatic send_random_file();
        int        width_px;
        int        height_px;
        int        pick;
        int        keep_len;
        longint    raster_len;
        stim_row_t row;
        file_bytes.delete();
        width_px = pick_dimension(1'b0);
        height_px = pick_dimension(1'b1);
        file_bytes.push_back(pbmp_pkg::CH_P);
        file_bytes.push_back(pbmp_pkg::CH_FOUR);
        push_blanks(1'b0);
        push_number(width_px);
        push_blanks(1'b0);
        push_number(height_px);
        push_blanks(1'b1);
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            file_bytes[0] = $urandom_range(0, 1) ? pbmp_pkg::CH_P : 8'($urandom_range(0, 255));
            file_bytes[1] = 8'($urandom_range(0, 255));
        end
        else if (pick < 13)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if (pick >= 13 && pick < 18)
        begin
            keep_len = $urandom_range(0, file_bytes.size() - 1);
            while (file_bytes.size() > keep_len)
                void'(file_bytes.pop_back());
        end
        else
        begin
            raster_len = longint'((width_px + 7) / 8) * longint'(height_px);
            if (raster_len > 48)
                raster_len = $urandom_range(0, 12);
            else if (raster_len > 0 && $urandom_range(0, 9) == 0)
                raster_len = $urandom_range(0, int'(raster_len) - 1);
            repeat (raster_len + $urandom_range(0, 3))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        row = '0;
        foreach (file_bytes[i])
        begin
            row.stim.op = pbmp_pkg::OP_BYTE;
            row.stim.byte_value = file_bytes[i];
            send_item(row);
        end
        row.stim.op = pbmp_pkg::OP_EOS;
        row.stim.byte_value = 8'($urandom_range(0, 255));
        send_item(row);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
        int start_count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start_count = items_sent;
        while (items_sent - start_count < budget)
            send_random_file();
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready = 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            result_ready = 1'b0;
        end
        else
            result_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_ready)
            input_stall_cycles++;
    end

    always @(posedge clk)
    begin : check_results
        pbmp_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            case (result.kind)
                pbmp_pkg::KIND_HEADER: headers_seen++;
                pbmp_pkg::KIND_PIXEL:  pixels_seen++;
                default:               errors_seen++;
            endcase
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result kind %0d with nothing expected",
                                          result.kind));
            else
            begin
                want = expected_results.pop_front();
                if (result.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", result.kind, want.kind));
                if (result.image_width !== want.image_width)
                    report_mismatch($sformatf("image_width %0d, want %0d",
                                              result.image_width, want.image_width));
                if (result.image_height !== want.image_height)
                    report_mismatch($sformatf("image_height %0d, want %0d",
                                              result.image_height, want.image_height));
                if (result.pixel_byte !== want.pixel_byte)
                    report_mismatch($sformatf("pixel_byte %h, want %h",
                                              result.pixel_byte, want.pixel_byte));
                if (result.last_byte !== want.last_byte)
                    report_mismatch($sformatf("last_byte %b, want %b",
                                              result.last_byte, want.last_byte));
                if (result.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              result.error_code, want.error_code));
            end
        end
    end

    initial
    begin
        clear_parser();
        // End of stream at once, bad magic, NUL after the magic, a width one past
        // the limit, then a 1x1 image whose header uses tab, VT and FF blanks and
        // a comment, closed by LF, that also ends the width.
        directed_rows = '{
            '{'{pbmp_pkg::OP_EOS, 8'h00}, 1'b1, 1'b1, error_result(pbmp_pkg::ERR_SHORT_MAGIC)},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_P}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h00}, 1'b1, 1'b1, error_result(pbmp_pkg::ERR_BAD_MAGIC)},
            '{'{pbmp_pkg::OP_EOS, 8'hFF}, 1'b1, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_P}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_FOUR}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h00}, 1'b1, 1'b1, error_result(pbmp_pkg::ERR_SPACE_MAGIC)},
            '{'{pbmp_pkg::OP_EOS, 8'h00}, 1'b1, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_P}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_FOUR}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h20}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h36}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h35}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h35}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h33}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h36}, 1'b1, 1'b1, error_result(pbmp_pkg::ERR_TOO_LARGE)},
            '{'{pbmp_pkg::OP_EOS, 8'h00}, 1'b1, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_P}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_FOUR}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h09}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h31}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_HASH}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, pbmp_pkg::CH_LF}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h0B}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h31}, 1'b0, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_BYTE, 8'h0C}, 1'b1, 1'b1, header_result(16'd1, 16'd1)},
            '{'{pbmp_pkg::OP_BYTE, 8'hAA}, 1'b1, 1'b1, pixel_result(8'hAA, 1'b1)},
            '{'{pbmp_pkg::OP_BYTE, 8'hFF}, 1'b1, 1'b0, NO_RESULT},
            '{'{pbmp_pkg::OP_EOS, 8'h00}, 1'b1, 1'b0, NO_RESULT}
        };
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // The long hold-off lands on busy traffic with the sender never idle.
        hold_requests++;
        run_phase(0, 0, 250);
        run_phase(58, 0, 250);
        run_phase(0, 58, 250);
        run_phase(20, 20, 250);
        item_valid = 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d directed) over four idle and stall mixes;",
                 items_sent, NUM_DIRECTED);
        $display("saw %0d headers, %0d raster bytes, %0d errors; input stalled %0d cycles.",
                 headers_seen, pixels_seen, errors_seen, input_stall_cycles);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### pbm_p4_stream_parser_core.f
+incdir+rtl
rtl/pbmp_pkg.sv
rtl/pbmp_step_engine.sv
rtl/pbm_p4_stream_parser_core.sv
tb/sv/tb_pbm_p4_stream_parser_core.sv
